// ===== hdl/siprpg_pkg.sv =====
// Shared types and constants for the permutation-to-graph edge encoder.
// No dependencies.
package siprpg_pkg;

  localparam int unsigned MaxPermLen = 64;
  localparam int unsigned StackSlots = MaxPermLen + 1;
  localparam int unsigned DepthW     = $clog2(StackSlots + 1);
  localparam int unsigned AddrW      = $clog2(StackSlots);

  localparam int unsigned ValueW = 6;
  localparam int unsigned NodeW  = 7;

  localparam logic [NodeW-1:0] FwdOffset  = NodeW'(2);
  localparam logic [NodeW-1:0] BackOffset = NodeW'(1);
  localparam logic [NodeW-1:0] LenReset   = NodeW'(1);

  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam logic [PaddrW-3:0] RegPermLength = '0;

  typedef struct packed {
    logic [ValueW-1:0] perm_value;
    logic              first_of_perm;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0] node_index;
    logic [NodeW-1:0] back_target;
    logic [NodeW-1:0] fwd_target;
    logic             value_error;
  } out_item_t;

  typedef struct packed {
    logic [NodeW-1:0] perm_length;
  } cfg_t;

endpackage

// ===== hdl/siprpg_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on siprpg_pkg.
module siprpg_regs import siprpg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [NodeW-1:0] perm_length_q;
  logic [NodeW-1:0] perm_length_d;
  logic             sel_len;

  assign pready  = 1'b1;
  assign sel_len = (paddr[PaddrW-1:2] == RegPermLength);

  always_comb begin
    perm_length_d = perm_length_q;
    if (psel && penable && pwrite && pready && sel_len) begin
      perm_length_d = pwdata[NodeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_length_q <= LenReset;
    end else begin
      perm_length_q <= perm_length_d;
    end
  end

  assign prdata            = sel_len ? {{(PdataW-NodeW){1'b0}}, perm_length_q} : '0;
  assign cfg_o.perm_length = perm_length_q;

endmodule

// ===== hdl/sip_to_rpg_edge_encoder_core.sv =====
// Top level of the permutation-to-graph edge encoder: stack memory and walk control.
// Depends on siprpg_pkg and siprpg_regs.
//
// When nothing is popped, the transfer cycle loads a permutation value, and the WALK
// state then writes the result register and pushes the value once the output is free.
// Each popped stack entry passes through the FETCH state, where the registered read of
// the stack memory refills the top-of-stack register. Every in-range value is pushed
// once, so pops average at most one per item over a permutation. Out-of-range
// values leave the stack untouched. A value is taken only while the walk is idle; the
// result register lets the next value enter while a result still waits downstream.
module sip_to_rpg_edge_encoder_core import siprpg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    IDLE,
    WALK,
    FETCH
  } state_e;

  cfg_t cfg;

  siprpg_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  state_e            state_q;
  logic [DepthW-1:0] depth_q;
  logic [NodeW-1:0]  top_q;
  logic [ValueW-1:0] v_q;
  logic [NodeW-1:0]  n_q;
  logic              err_q;
  logic              out_valid_q;
  out_item_t         out_data_q;

  logic [NodeW-1:0] stack_mem [StackSlots];
  logic [NodeW-1:0] rd_data_q;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [NodeW-1:0] wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;

  logic             in_xfer;
  logic             out_free;
  logic [NodeW-1:0] in_v7;
  logic             in_err;
  logic             reload;
  logic [NodeW-1:0] v7;
  logic             pop_more;
  logic             emit;
  logic             push;
  logic             stack_full;
  out_item_t        result;
  logic [DepthW-1:0] depth_dec;
  logic [DepthW-1:0] depth_dec2;

  assign in_stall_o  = (state_q != IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign in_v7  = {1'b0, in_data_i.perm_value};
  assign in_err = (in_v7 >= cfg.perm_length);
  assign reload = in_xfer && !in_err && (in_data_i.first_of_perm || (depth_q == '0));

  assign v7         = {1'b0, v_q};
  assign depth_dec  = depth_q - DepthW'(1);
  assign depth_dec2 = depth_q - DepthW'(2);
  assign pop_more   = !err_q && (depth_q > DepthW'(1)) && (top_q < v7);
  assign emit       = (state_q == WALK) && !pop_more && out_free;
  assign push       = emit && !err_q;
  assign stack_full = (depth_q >= DepthW'(StackSlots));
  assign rd_en      = (state_q == WALK) && pop_more;
  assign rd_addr    = depth_dec2[AddrW-1:0];

  always_comb begin
    if (err_q) begin
      result = '{node_index: '0, back_target: '0, fwd_target: '0, value_error: 1'b1};
    end else begin
      result.node_index  = n_q + BackOffset - v7;
      result.back_target = n_q + BackOffset - top_q;
      result.fwd_target  = (v_q == '0) ? '0 : (n_q + FwdOffset - v7);
      result.value_error = 1'b0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = cfg.perm_length;
    if (reload) begin
      wr_en = 1'b1;
    end else if (push) begin
      wr_en   = 1'b1;
      wr_addr = stack_full ? AddrW'(StackSlots - 1) : depth_q[AddrW-1:0];
      wr_data = v7;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      depth_q     <= '0;
      top_q       <= '0;
      v_q         <= '0;
      n_q         <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: begin
          if (in_xfer) begin
            v_q     <= in_data_i.perm_value;
            n_q     <= cfg.perm_length;
            err_q   <= in_err;
            state_q <= WALK;
            if (reload) begin
              depth_q <= DepthW'(1);
              top_q   <= cfg.perm_length;
            end
          end
        end
        WALK: begin
          if (pop_more) begin
            depth_q <= depth_dec;
            state_q <= FETCH;
          end else if (out_free) begin
            out_data_q  <= result;
            state_q     <= IDLE;
            if (!err_q) begin
              top_q <= v7;
              if (!stack_full) begin
                depth_q <= depth_q + DepthW'(1);
              end
            end
          end
        end
        FETCH: begin
          top_q   <= rd_data_q;
          state_q <= WALK;
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(StackSlots))
    else $error("stack depth beyond capacity");

  a_err_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.value_error |->
      (out_data_o.node_index == '0) && (out_data_o.back_target == '0) &&
      (out_data_o.fwd_target == '0))
    else $error("error result carries nonzero fields");

  a_push_sets_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (top_q == {1'b0, $past(v_q)}) && (depth_q != '0))
    else $error("top of stack not the pushed value");

  a_pop_keeps_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FETCH |-> depth_q >= DepthW'(1))
    else $error("pop removed the bottom entry");

  a_err_keeps_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WALK) && err_q |=> $stable(depth_q) && $stable(top_q))
    else $error("out-of-range value changed the stack");

endmodule
